// ----- hw/rtl/mbps_pkg.sv -----
package mbps_pkg;

	localparam int REG_BYTES = 16;
	localparam int LEN_W     = 5;
	localparam int ADDR_W    = 48;
	localparam int CNT_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 64;

	typedef logic [7:0] byte_t;
	typedef byte_t [REG_BYTES-1:0] pat_t;

	typedef enum logic [1:0] {
		CMD_CONT   = 2'd0,
		CMD_REGION = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LENGTH   = 3'd0,
		REG_PAT_LOW  = 3'd1,
		REG_PAT_HIGH = 3'd2,
		REG_MASK     = 3'd3,
		REG_LIMIT    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic shift;
		logic flush;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/mbps_cell.sv -----
module mbps_cell
	import mbps_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  byte_t            prev_byte,
	input  logic             prev_valid,
	input  logic [LEN_W-1:0] eff_len,
	input  pat_t             pattern,
	input  logic [REG_BYTES-1:0] mask,
	output byte_t            cur_byte,
	output logic             cur_valid,
	output logic             ok
);

	localparam logic [6:0] POS = 7'(IDX);

	byte_t      byte_q;
	logic       valid_q;
	logic [6:0] len_x;
	logic [6:0] pidx_x;
	logic       in_use;
	logic [3:0] pidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= ctl.flush ? 1'b0 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= ctl.flush ? 8'h00 : prev_byte;
		end
	end

	always_comb begin
		len_x  = {2'b00, eff_len};
		pidx_x = len_x - 7'd1 - POS;
		in_use = POS < len_x;
		pidx   = pidx_x[3:0];
		ok     = !in_use || (valid_q && (!mask[pidx] || byte_q == pattern[pidx]));
	end

	assign cur_byte  = byte_q;
	assign cur_valid = valid_q;

endmodule

// ----- hw/rtl/masked_byte_pattern_scan.sv -----
// Masked byte pattern scan: takes one byte item per cycle, back to back, while
// in_ready is high, and shifts it into a row of PAT_MAX window cells; each cell
// compares its byte with the pattern byte for its place, and a match is registered
// into the output stage from the compare stage. The match count sits in the output
// stage, so a stalled output holds at most one further byte in the compare stage
// before in_ready drops; bytes that give no result keep flowing while a result waits.
module masked_byte_pattern_scan
	import mbps_pkg::*;
#(
	parameter int PAT_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [7:0]           data_byte,
	input  logic [ADDR_W-1:0]    byte_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_W-1:0]    match_address,
	output logic [CNT_W-1:0]     match_number,
	output logic                 limit_reached,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam logic [LEN_W-1:0] CAP_LEN =
		LEN_W'(PAT_MAX < REG_BYTES ? PAT_MAX : REG_BYTES);

	logic [LEN_W-1:0]     length_q;
	logic [63:0]          pat_low_q;
	logic [63:0]          pat_high_q;
	logic [REG_BYTES-1:0] mask_q;
	logic [CNT_W-1:0]     limit_q;

	logic [LEN_W-1:0] eff_len;
	pat_t             pattern;

	byte_t              cell_byte [PAT_MAX];
	logic [PAT_MAX-1:0] cell_valid;
	logic [PAT_MAX-1:0] cell_ok;
	cell_ctl_t          ctl_head;
	cell_ctl_t          ctl_tail;

	logic              s1_valid_s1;
	logic              s1_byte_s1;
	logic              s1_search_s1;
	logic [ADDR_W-1:0] s1_addr_s1;

	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [CNT_W-1:0]  out_num_q;
	logic              out_last_q;

	logic              accept;
	cmd_t              cmd;
	logic              hit;
	logic              emit;
	logic              out_free;
	logic              s1_adv;
	logic [CNT_W-1:0]  count_next;
	logic [ADDR_W-1:0] first_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= LEN_W'(1);
			pat_low_q  <= '0;
			pat_high_q <= '0;
			mask_q     <= '1;
			limit_q    <= CNT_W'(500);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LENGTH:   length_q   <= cfg_data[LEN_W-1:0];
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_MASK:     mask_q     <= cfg_data[REG_BYTES-1:0];
				REG_LIMIT:    limit_q    <= cfg_data[CNT_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		if (length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (length_q > CAP_LEN) begin
			eff_len = CAP_LEN;
		end else begin
			eff_len = length_q;
		end
		pattern = {pat_high_q, pat_low_q};
	end

	assign cmd    = cmd_t'(command);
	assign accept = in_valid && in_ready;

	always_comb begin
		ctl_head.shift = accept && (cmd != CMD_UNUSED);
		ctl_head.flush = cmd == CMD_SEARCH;
		ctl_tail.shift = ctl_head.shift;
		ctl_tail.flush = (cmd == CMD_SEARCH) || (cmd == CMD_REGION);
	end

	for (genvar k = 0; k < PAT_MAX; k++) begin : g_cell
		if (k == 0) begin : g_head
			mbps_cell #(.IDX(k)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl_head),
				.prev_byte  (data_byte),
				.prev_valid (1'b1),
				.eff_len    (eff_len),
				.pattern    (pattern),
				.mask       (mask_q),
				.cur_byte   (cell_byte[k]),
				.cur_valid  (cell_valid[k]),
				.ok         (cell_ok[k])
			);
		end else begin : g_body
			mbps_cell #(.IDX(k)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl_tail),
				.prev_byte  (cell_byte[k-1]),
				.prev_valid (cell_valid[k-1]),
				.eff_len    (eff_len),
				.pattern    (pattern),
				.mask       (mask_q),
				.cur_byte   (cell_byte[k]),
				.cur_valid  (cell_valid[k]),
				.ok         (cell_ok[k])
			);
		end
	end

	always_comb begin
		hit        = &cell_ok;
		emit       = s1_valid_s1 && s1_byte_s1 && hit && (count_q < limit_q);
		out_free   = !out_valid_q || out_ready;
		s1_adv     = !s1_valid_s1 || !emit || out_free;
		count_next = count_q + CNT_W'(1);
		first_addr = s1_addr_s1 - ADDR_W'(eff_len - LEN_W'(1));
	end

	assign in_ready = s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s1_byte_s1   <= (cmd == CMD_CONT) || (cmd == CMD_REGION);
			s1_search_s1 <= cmd == CMD_SEARCH;
			s1_addr_s1   <= byte_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv && s1_valid_s1 && s1_search_s1) begin
				count_q <= '0;
			end else if (s1_adv && emit) begin
				count_q <= count_next;
			end
			if (s1_adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			out_addr_q <= first_addr;
			out_num_q  <= count_next;
			out_last_q <= count_next == limit_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = out_addr_q;
	assign match_number  = out_num_q;
	assign limit_reached = out_last_q;

endmodule
